// ===== hdl/triangle_count_sorted_intersection_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the triangle counter
// Each macro expects signals named clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_COUNT_SORTED_INTERSECTION_ASSERT_SVH
`define TRIANGLE_COUNT_SORTED_INTERSECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCSI_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcsi check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcsi check failed");

`endif

// ===== hdl/tcsi_pkg.sv =====
// ---------------------------------------------------------------------------
// tcsi_pkg
// Shared types and default sizes for the triangle counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcsi_pkg;

	localparam int unsigned TCSI_MAX_VERTICES = 1024;
	localparam int unsigned TCSI_MAX_EDGES    = 16384;
	localparam int unsigned TCSI_MAX_DEGREE   = 1024;

	localparam int unsigned ID_W  = 10;
	localparam int unsigned TRI_W = 48;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_ADD   = 2'd1,
		OP_COUNT = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

endpackage

// ===== hdl/tcsi_ram.sv =====
// ---------------------------------------------------------------------------
// tcsi_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/triangle_count_sorted_intersection.sv =====
// ---------------------------------------------------------------------------
// triangle_count_sorted_intersection
// Begin vertex: table write on accept. Add neighbour: scan the list up to p,
// p the insert position, then shift the tail up by one. Clear: sweep of all MAX_VERTICES table entries.
// Count: walks every vertex slot, each kept edge and each merge step,
// all through the single read port of the edge RAM; result registered last.
// Reset: control cleared, then the same table sweep as clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_count_sorted_intersection #(
	parameter int unsigned MAX_VERTICES = tcsi_pkg::TCSI_MAX_VERTICES,
	parameter int unsigned MAX_EDGES    = tcsi_pkg::TCSI_MAX_EDGES,
	parameter int unsigned MAX_DEGREE   = tcsi_pkg::TCSI_MAX_DEGREE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [tcsi_pkg::ID_W-1:0]  vertex_id,
	input  logic [tcsi_pkg::ID_W-1:0]  neighbour_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcsi_pkg::TRI_W-1:0] triangles,
	output logic                       status
);

	import tcsi_pkg::*;

	`include "triangle_count_sorted_intersection_assert.svh"

	// Address and field widths.
	localparam int AW  = $clog2(MAX_VERTICES);   // vertex table index
	localparam int EW  = $clog2(MAX_EDGES);      // edge RAM index
	localparam int SW  = EW + 1;                 // fill / list start, holds MAX_EDGES
	localparam int DW  = $clog2(MAX_DEGREE + 1); // list length, holds MAX_DEGREE
	localparam int VWD = 1 + SW + DW;            // {loaded, start, length}

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_ADD_DEC,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_CNT_VRD,
		ST_CNT_VCHK,
		ST_CNT_JRD,
		ST_CNT_JU,
		ST_CNT_UCHK,
		ST_M_A,
		ST_M_B,
		ST_M_CMP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [SW-1:0]     fill_q;
	logic [ID_W-1:0]   cur_q;
	logic              cur_ok_q;     // current vertex has a list
	logic [SW-1:0]     cur_start_q;
	logic [DW-1:0]     cur_len_q;
	logic              ovf_q;
	logic [ID_W-1:0]   nb_q;
	logic [DW-1:0]     p_q;          // insert position
	logic [DW-1:0]     i_q;          // shift index
	logic [AW-1:0]     v_q;          // count walk / clear sweep index
	logic [SW-1:0]     vs_q;
	logic [DW-1:0]     vlen_q;
	logic [DW-1:0]     j_q;
	logic [SW-1:0]     us_q;
	logic [DW-1:0]     ulen_q;
	logic [DW-1:0]     k_q;
	logic [DW-1:0]     m_q;
	logic [ID_W-1:0]   a_q;
	logic [TRI_W-1:0]  total_q;
	logic              out_valid_q;
	logic [TRI_W-1:0]  tri_q;
	logic              status_q;

	// Memory ports.
	logic              v_we;
	logic [AW-1:0]     v_waddr;
	logic [VWD-1:0]    v_wdata;
	logic [AW-1:0]     v_raddr;
	logic [VWD-1:0]    v_rdata;
	logic              e_we;
	logic [EW-1:0]     e_waddr;
	logic [ID_W-1:0]   e_wdata;
	logic [EW-1:0]     e_raddr;
	logic [ID_W-1:0]   e_rdata;

	logic              vr_loaded;
	logic [SW-1:0]     vr_start;
	logic [DW-1:0]     vr_len;
	logic              accept;
	logic              vid_ok;
	logic              ins_done;
	logic              last_v;

	assign vr_loaded = v_rdata[VWD-1];
	assign vr_start  = v_rdata[VWD-2 -: SW];
	assign vr_len    = v_rdata[DW-1:0];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign vid_ok   = 32'(vertex_id) < 32'(MAX_VERTICES);
	assign ins_done = (state_q == ST_SHIFT_RD) && (i_q == p_q);
	assign last_v   = (v_q == AW'(MAX_VERTICES - 1));

	// Vertex table: one entry per vertex, swept to zero on clear and reset.
	always_comb begin
		v_we    = 1'b0;
		v_waddr = v_q;
		v_wdata = '0;
		if (state_q == ST_CLR) begin
			v_we = 1'b1;
		end else if (accept && op_t'(opcode) == OP_BEGIN && vid_ok) begin
			v_we    = 1'b1;
			v_waddr = AW'(vertex_id);
			v_wdata = {1'b1, fill_q, DW'(0)};
		end else if (ins_done) begin
			v_we    = 1'b1;
			v_waddr = AW'(cur_q);
			v_wdata = {1'b1, cur_start_q, DW'(cur_len_q + 1'b1)};
		end
	end

	// Neighbour IDs at or above MAX_VERTICES reach this read truncated; ST_CNT_JU discards the result.
	assign v_raddr = (state_q == ST_CNT_JU) ? AW'(e_rdata) : v_q;

	// Edge RAM addressing. The current list always ends at fill, so the
	// insert shifts its tail up by one, from the end down.
	always_comb begin
		case (state_q)
			ST_ADD_RD:   e_raddr = EW'(cur_start_q + p_q);
			ST_SHIFT_RD: e_raddr = EW'(cur_start_q + i_q - 1'b1);
			ST_CNT_JRD:  e_raddr = EW'(vs_q + j_q);
			ST_M_A:      e_raddr = EW'(us_q + k_q);
			ST_M_B:      e_raddr = EW'(vs_q + m_q);
			default:     e_raddr = '0;
		endcase
	end

	always_comb begin
		e_we    = 1'b0;
		e_waddr = EW'(cur_start_q + i_q);
		e_wdata = e_rdata;
		if (state_q == ST_SHIFT_WR) begin
			e_we = 1'b1;
		end else if (ins_done) begin
			e_we    = 1'b1;
			e_waddr = EW'(cur_start_q + p_q);
			e_wdata = nb_q;
		end
	end

	tcsi_ram #(.WIDTH(VWD), .DEPTH(MAX_VERTICES)) u_vtab (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	tcsi_ram #(.WIDTH(ID_W), .DEPTH(MAX_EDGES)) u_edges (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Sequencer: command decode, clear sweep, sorted insert, the count walk and the output handoff.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			fill_q      <= '0;
			cur_q       <= '0;
			cur_ok_q    <= 1'b0;
			ovf_q       <= 1'b0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// ST_DONE does its own output handoff.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					v_q <= v_q + 1'b1;
					if (last_v) begin
						v_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op_t'(opcode))
							OP_BEGIN: begin
								cur_q       <= vertex_id;
								cur_ok_q    <= vid_ok;
								cur_start_q <= fill_q;
								cur_len_q   <= '0;
							end
							OP_ADD: begin
								nb_q <= neighbour_id;
								p_q  <= '0;
								if (cur_ok_q && neighbour_id > cur_q) begin
									state_q <= ST_ADD_RD;
								end
							end
							OP_COUNT: begin
								v_q     <= '0;
								total_q <= '0;
								state_q <= ST_CNT_VRD;
							end
							default: begin
								fill_q   <= '0;
								cur_q    <= '0;
								cur_ok_q <= 1'b0;
								ovf_q    <= 1'b0;
								v_q      <= '0;
								state_q  <= ST_CLR;
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					state_q <= (p_q == cur_len_q) ? ST_ADD_DEC : ST_ADD_CMP;
				end
				ST_ADD_CMP: begin
					if (e_rdata < nb_q) begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_ADD_RD;
					end else if (e_rdata == nb_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ADD_DEC;
					end
				end
				ST_ADD_DEC: begin
					if (fill_q >= SW'(MAX_EDGES) || cur_len_q >= DW'(MAX_DEGREE)) begin
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						i_q     <= cur_len_q;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SHIFT_RD: begin
					if (ins_done) begin
						cur_len_q <= cur_len_q + 1'b1;
						fill_q    <= fill_q + 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_SHIFT_WR;
					end
				end
				ST_SHIFT_WR: begin
					i_q     <= i_q - 1'b1;
					state_q <= ST_SHIFT_RD;
				end
				ST_CNT_VRD: begin
					state_q <= ST_CNT_VCHK;
				end
				ST_CNT_VCHK: begin
					vs_q   <= vr_start;
					vlen_q <= vr_len;
					j_q    <= '0;
					if (vr_loaded) begin
						state_q <= ST_CNT_JRD;
					end else if (last_v) begin
						state_q <= ST_DONE;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_CNT_VRD;
					end
				end
				ST_CNT_JRD: begin
					if (j_q != vlen_q) begin
						state_q <= ST_CNT_JU;
					end else if (last_v) begin
						state_q <= ST_DONE;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= ST_CNT_VRD;
					end
				end
				ST_CNT_JU: begin
					if (32'(e_rdata) < 32'(MAX_VERTICES)) begin
						state_q <= ST_CNT_UCHK;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CNT_JRD;
					end
				end
				ST_CNT_UCHK: begin
					us_q   <= vr_start;
					ulen_q <= vr_len;
					k_q    <= '0;
					m_q    <= j_q + 1'b1;
					if (vr_loaded) begin
						state_q <= ST_M_A;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CNT_JRD;
					end
				end
				ST_M_A: begin
					if (k_q < ulen_q && m_q < vlen_q) begin
						state_q <= ST_M_B;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CNT_JRD;
					end
				end
				ST_M_B: begin
					a_q     <= e_rdata;
					state_q <= ST_M_CMP;
				end
				ST_M_CMP: begin
					if (a_q == e_rdata) begin
						if (total_q != '1) begin
							total_q <= total_q + 1'b1;
						end
						k_q <= k_q + 1'b1;
						m_q <= m_q + 1'b1;
					end else if (a_q > e_rdata) begin
						m_q <= m_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
					state_q <= ST_M_A;
				end
				ST_DONE: begin
					// Wait for the output register to be free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						tri_q       <= total_q;
						status_q    <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign triangles = tri_q;
	assign status    = status_q;

	// A count command starts the vertex walk right away.
	`TCSI_ASSERT_NEXT(a_count_starts, accept && op_t'(opcode) == OP_COUNT, state_q == ST_CNT_VRD)
	// The edge fill never passes the store size.
	`TCSI_ASSERT_HOLDS(a_fill_bound, 1'b1, fill_q <= SW'(MAX_EDGES))
	// A merge read is only issued inside both lists.
	`TCSI_ASSERT_HOLDS(a_merge_bounds, state_q == ST_M_B, k_q < ulen_q && m_q < vlen_q)
	// An insert never grows the list past its degree limit.
	`TCSI_ASSERT_HOLDS(a_degree_bound, ins_done, cur_len_q < DW'(MAX_DEGREE))

endmodule

// ===== verif/tb_triangle_count_sorted_intersection.sv =====
// ---------------------------------------------------------------------------
// tb_triangle_count_sorted_intersection
// Self-checking bench: graph words go in through a driver queue, an in-bench
// graph model predicts each triangle count, and a monitor compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_count_sorted_intersection;
	import tcsi_pkg::*;

	localparam int unsigned NV = TCSI_MAX_VERTICES;
	localparam int unsigned NE = TCSI_MAX_EDGES;
	localparam int unsigned ND = TCSI_MAX_DEGREE;
	localparam logic [TRI_W-1:0] TRI_SAT = {TRI_W{1'b1}};

	typedef struct packed {
		op_t            op;
		logic [ID_W-1:0] vid;
		logic [ID_W-1:0] nb;
	} graph_word_t;

	typedef struct packed {
		logic [TRI_W-1:0] tri_total;
		logic             ovf;
	} count_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          opcode;
	logic [ID_W-1:0]     vertex_id;
	logic [ID_W-1:0]     neighbour_id;
	logic                out_valid;
	logic                out_stall;
	logic [TRI_W-1:0]    triangles;
	logic                status;

	graph_word_t   word_q[$];
	count_result_t count_q[$];
	int            errors = 0;

	// graph model state
	int unsigned     g_start[NV];
	int unsigned     g_len[NV];
	bit              g_loaded[NV];
	logic [ID_W-1:0] g_edges[NE];
	int unsigned     g_fill;
	int unsigned     g_cur;
	bit              g_ovf;

	triangle_count_sorted_intersection uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .vertex_id(vertex_id), .neighbour_id(neighbour_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.triangles(triangles), .status(status)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// sorted insert into the current vertex list; the list always ends at g_fill
	function automatic void graph_add(int unsigned nb);
		int unsigned v, s, len, p;
		v = g_cur;
		if (v >= NV || !g_loaded[v] || nb <= v)
			return;
		s = g_start[v];
		len = g_len[v];
		p = 0;
		while (p < len && g_edges[s + p] < nb)
			p++;
		if (p < len && g_edges[s + p] == nb)
			return;
		if (g_fill >= NE || len >= ND) begin
			g_ovf = 1'b1;
			return;
		end
		for (int i = int'(len); i > int'(p); i--)
			g_edges[s + i] = g_edges[s + i - 1];
		g_edges[s + p] = nb[ID_W-1:0];
		g_len[v] = len + 1;
		g_fill++;
	endfunction

	// every v < u < w found by merging u's list with the tail of v's list
	function automatic logic [TRI_W-1:0] graph_triangles();
		logic [63:0] total;
		int unsigned vs, vl, u, us, ul, k, m;
		total = 0;
		for (int v = 0; v < NV; v++) begin
			if (!g_loaded[v])
				continue;
			vs = g_start[v];
			vl = g_len[v];
			for (int j = 0; j < vl; j++) begin
				u = g_edges[vs + j];
				if (u >= NV || !g_loaded[u])
					continue;
				us = g_start[u];
				ul = g_len[u];
				k = 0;
				m = j + 1;
				while (k < ul && m < vl) begin
					if (g_edges[us + k] == g_edges[vs + m]) begin
						if (total < TRI_SAT)
							total++;
						k++;
						m++;
					end else if (g_edges[us + k] > g_edges[vs + m]) begin
						m++;
					end else begin
						k++;
					end
				end
			end
		end
		return total[TRI_W-1:0];
	endfunction

	function automatic void graph_apply(graph_word_t w);
		count_result_t r;
		case (w.op)
			OP_BEGIN: begin
				g_cur = w.vid;
				if (w.vid < NV) begin
					g_start[w.vid] = g_fill;
					g_len[w.vid] = 0;
					g_loaded[w.vid] = 1'b1;
				end
			end
			OP_ADD: graph_add(w.nb);
			OP_COUNT: begin
				r.tri_total = graph_triangles();
				r.ovf = g_ovf;
				count_q = {count_q, r};
			end
			default: begin
				for (int i = 0; i < NV; i++)
					g_loaded[i] = 1'b0;
				g_fill = 0;
				g_cur = 0;
				g_ovf = 1'b0;
			end
		endcase
	endfunction

	// the tail of the run goes without idling on either side
	function automatic bit calm();
		return word_q.size() < 120;
	endfunction

	// driver: one NBA per signal per edge, payload held while stalled
	int src_idle = 0;
	always @(posedge clk or negedge arst_n) begin
		graph_word_t w;
		bit          take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_BEGIN;
			vertex_id <= '0;
			neighbour_id <= '0;
			src_idle <= 0;
		end else begin
			if (in_valid && !in_stall)
				graph_apply(graph_word_t'({op_t'(opcode), vertex_id, neighbour_id}));
			if (!(in_valid && in_stall)) begin
				take = 1'b0;
				if (src_idle > 0) begin
					src_idle <= src_idle - 1;
				end else if (word_q.size() > 0) begin
					if (!calm() && $urandom_range(0, 9) == 0)
						src_idle <= $urandom_range(0, 10);
					else
						take = 1'b1;
				end
				if (take) begin
					w = word_q.pop_front();
					opcode <= w.op;
					vertex_id <= w.vid;
					neighbour_id <= w.nb;
				end
				in_valid <= take;
			end
		end
	end

	// monitor: random stall bursts, checks each accepted count result
	int snk_idle = 0;
	always @(posedge clk or negedge arst_n) begin
		count_result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			snk_idle <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (count_q.size() == 0) begin
					$error("unexpected result: triangles=%0d status=%0d", triangles, status);
					errors++;
				end else begin
					e = count_q.pop_front();
					if (triangles !== e.tri_total) begin
						$error("triangles: expected %0d, got %0d", e.tri_total, triangles);
						errors++;
					end
					if (status !== e.ovf) begin
						$error("status: expected %0d, got %0d", e.ovf, status);
						errors++;
					end
				end
			end
			if (snk_idle > 0) begin
				snk_idle <= snk_idle - 1;
				out_stall <= 1'b1;
			end else if (!calm() && $urandom_range(0, 7) == 0) begin
				snk_idle <= $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_word(op_t op, int unsigned vid, int unsigned nb);
		word_q = {word_q, graph_word_t'({op, vid[ID_W-1:0], nb[ID_W-1:0]})};
	endtask

	function automatic int unsigned rnd_id();
		return $urandom_range(0, NV - 1);
	endfunction

	initial begin
		int unsigned base, span, nv, na, v;
		g_fill = 0;
		g_cur = 0;
		g_ovf = 1'b0;
		for (int i = 0; i < NV; i++) begin
			g_loaded[i] = 1'b0;
			g_start[i] = 0;
			g_len[i] = 0;
		end

		// directed: empty graph, add with no current list, one triangle,
		// repeats, lower/equal neighbours, unloaded neighbour, top vertex
		push_word(OP_COUNT, 1023, 1023);
		push_word(OP_ADD, 0, 5);
		push_word(OP_BEGIN, 0, 1023);
		push_word(OP_ADD, 1023, 2);
		push_word(OP_ADD, 0, 1);
		push_word(OP_ADD, 0, 2);
		push_word(OP_ADD, 0, 1);
		push_word(OP_ADD, 0, 0);
		push_word(OP_ADD, 0, 1023);
		push_word(OP_BEGIN, 1, 0);
		push_word(OP_ADD, 0, 1);
		push_word(OP_ADD, 0, 0);
		push_word(OP_ADD, 0, 2);
		push_word(OP_COUNT, 0, 0);
		push_word(OP_BEGIN, 1023, 0);
		push_word(OP_ADD, 0, 1022);
		push_word(OP_BEGIN, 2, 0);
		push_word(OP_ADD, 0, 1023);
		push_word(OP_COUNT, 0, 0);
		// re-begin replaces vertex 1's list, breaking the triangle
		push_word(OP_BEGIN, 1, 0);
		push_word(OP_ADD, 0, 3);
		push_word(OP_COUNT, 1023, 1023);
		push_word(OP_CLEAR, 1023, 1023);
		push_word(OP_ADD, 0, 9);
		push_word(OP_COUNT, 0, 0);

		// random: dense neighbourhoods of a small ID window, plus noise
		while (word_q.size() < 1350) begin
			if ($urandom_range(0, 2) == 0)
				push_word(OP_CLEAR, rnd_id(), rnd_id());
			base = $urandom_range(0, NV - 4);
			span = $urandom_range(3, 23);
			if (base + span > NV - 1)
				span = NV - 1 - base;
			nv = $urandom_range(2, 8);
			for (int i = 0; i < nv; i++) begin
				v = base + $urandom_range(0, span);
				push_word(OP_BEGIN, v, rnd_id());
				na = $urandom_range(0, 8);
				for (int j = 0; j < na; j++)
					push_word(OP_ADD, rnd_id(),
						($urandom_range(0, 7) == 0) ? rnd_id() : base + $urandom_range(0, span));
			end
			if ($urandom_range(0, 5) == 0)
				for (int j = $urandom_range(1, 4); j > 0; j--)
					push_word(op_t'($urandom_range(0, 3)), rnd_id(), rnd_id());
			push_word(OP_COUNT, rnd_id(), rnd_id());
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() > 0 || in_valid)
			@(posedge clk);
		while (count_q.size() > 0)
			@(posedge clk);
		// a trailing add or clear may still be in flight
		repeat (4000) @(posedge clk);
		if (errors == 0)
			$display("** triangle_count_sorted_intersection: PASSED **");
		else
			$display("** triangle_count_sorted_intersection: FAILED **");
		$finish;
	end

	initial begin
		#200ms;
		$display("** triangle_count_sorted_intersection: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcsi_pkg.sv
hdl/tcsi_ram.sv
hdl/triangle_count_sorted_intersection.sv
verif/tb_triangle_count_sorted_intersection.sv
